FILE: hdl/fdst_pkg.sv
// Package for the FP8 delayed scale tracker: sizes, codes and constants.
// No dependencies; imported by every module of the block.
`default_nettype none
package fdst_pkg;
  localparam int unsigned HistLen = 16;
  localparam int unsigned IdxW    = (HistLen > 1) ? $clog2(HistLen) : 1;
  localparam int unsigned CntW    = 5;

  localparam logic [31:0] OneBits    = 32'h3F80_0000;
  localparam logic [31:0] PosInfBits = 32'h7F80_0000;
  localparam logic [31:0] MaxFinBits = 32'h7F7F_FFFF;

  // ceil(2^31 / 7): exact floor division by seven for dividends below 2^28.
  localparam logic [28:0] Recip7 = 29'd306783379;

  localparam logic RegFormat = 1'b0;
  localparam logic RegMargin = 1'b1;

  typedef enum logic [2:0] {
    StIdle, StWrite, StScan, StScale, StDiv, StOut
  } state_e;
endpackage
`default_nettype wire

FILE: hdl/fdst_div.sv
// Binary32 divider by 448 or 57344 with round to nearest even.
// Uses fdst_pkg. Reciprocal multiplication by one seventh; operands, quotient and result are registered in turn.
`default_nettype none
module fdst_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] x_i,
  input  logic        fmt_i,
  output logic        done_o,
  output logic [31:0] q_o
);
  import fdst_pkg::*;

  // The divisor is 7 * 2^6 or 7 * 2^13: divide the significand by seven
  // and fix the exponent separately.
  logic [4:0]  lz;
  logic [23:0] sig_x;
  logic signed [10:0] kexp;
  logic signed [10:0] ed_x;

  logic        v1_q, v2_q, done_q;
  logic [27:0] num_q;
  logic signed [10:0] ed_q;
  logic        inf_q;
  logic [25:0] quo_q;
  logic        rem_nz_q;
  logic [31:0] q_q;

  logic [56:0] prod;
  logic [25:0] quo_c;
  logic [27:0] rem_c;

  logic signed [10:0] be;
  logic [4:0]  sh;
  logic [7:0]  ef;
  logic [53:0] shd;
  logic        rbit, sbit;
  logic [26:0] rnd;
  logic [31:0] res;

  // Leading-zero count of a subnormal mantissa.
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (x_i[i]) lz = 5'(22 - i);
    end
  end

  assign kexp = fmt_i ? 11'sd13 : 11'sd6;

  // The input is sig * 2^(ex - 23) with the leading one of sig at bit 23;
  // ed_x holds ex less the power of two of the divisor.
  always_comb begin
    if (x_i[30:23] != 8'd0) begin
      sig_x = {1'b1, x_i[22:0]};
      ed_x  = $signed({3'b000, x_i[30:23]}) - 11'sd127 - kexp;
    end else begin
      sig_x = {x_i[22:0], 1'b0} << lz;
      ed_x  = -11'sd127 - $signed({6'd0, lz}) - kexp;
    end
  end

  // Quotient and remainder of (sig * 16) / 7.
  assign prod  = 57'(num_q) * 57'(Recip7);
  assign quo_c = prod[56:31];
  assign rem_c = num_q - 28'({quo_c, 3'b000}) + 28'(quo_c);

  // The value is (quo + rem/7) * 2^(ed - 27). The leading one of quo sits at
  // bit 25 or 24; results below the normal range keep fewer bits.
  always_comb begin
    be = ed_q + 11'sd125 - (quo_q[25] ? 11'sd0 : 11'sd1);
    if (be >= 11'sd1) begin
      sh = quo_q[25] ? 5'd2 : 5'd1;
      ef = 8'(be - 11'sd1);
    end else begin
      sh = (ed_q < -11'sd149) ? 5'd27 : 5'(-11'sd122 - ed_q);
      ef = 8'd0;
    end
    shd  = {quo_q, 28'd0} >> sh;
    rbit = shd[27];
    sbit = (shd[26:0] != 27'd0) || rem_nz_q;
    rnd  = {1'b0, shd[53:28]} + 27'(rbit && (sbit || shd[28]));
    // A carry out of the significand moves into the exponent field by itself.
    res  = inf_q ? PosInfBits : ({1'b0, ef, 23'd0} + 32'(rnd));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {sig_x, 4'd0};
      ed_q  <= ed_x;
      inf_q <= (x_i == PosInfBits);
    end
    if (v1_q) begin
      quo_q    <= quo_c;
      rem_nz_q <= (rem_c != 28'd0);
    end
    if (v2_q) q_q <= res;
  end

  assign done_o = done_q;
  assign q_o    = q_q;
endmodule
`default_nettype wire

FILE: hdl/fp8_delayed_scale_tracker_core.sv
// Top level of the FP8 delayed scale tracker: history memory, scan and control.
// Uses fdst_pkg and fdst_div.
`default_nettype none
// Each item writes one amax into a 16-entry history memory, scans the whole
// memory one entry a cycle for the largest value, applies the margin one
// doubling a cycle and divides by the FP8 maximum with a reciprocal divider.
// The steps of an item, in order: accept, write, scan, scale (ended early
// when the value reaches infinity), divide and hand over the result; when
// every entry is zero the divider is skipped and the scale is one. The next
// item is taken once the result has been accepted.
// No clearing pass: entries beyond the fill count are read as zero.
module fp8_delayed_scale_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] amax_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] scale_bits_o,
  output logic [4:0]  filled_count_o
);
  import fdst_pkg::*;

  logic [31:0] mem [HistLen];
  logic [31:0] rd_q;
  logic [IdxW-1:0] rd_addr;

  state_e state_q, state_d;
  logic        fmt_q;
  logic [7:0]  margin_q, mcnt_q;
  logic [IdxW-1:0] wpos_q, scan_q;
  logic [CntW-1:0] fill_q;
  logic [31:0] amax_q, best_q, scale_q;
  logic        rd_vld_q, scan_last_q;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic [IdxW:0] scan_ext;

  assign scan_ext = {1'b0, scan_q};

  always_ff @(posedge clk_i) begin
    if (state_q == StWrite) mem[wpos_q] <= amax_q;
    rd_q <= mem[rd_addr];
  end
  assign rd_addr = scan_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StWrite;
      StWrite: state_d = StScan;
      StScan:  if (scan_last_q) state_d = StScale;
      StScale: if (best_q == 32'd0) state_d = StOut;
               else if (mcnt_q == margin_q || best_q == PosInfBits) state_d = StDiv;
      StDiv:   if (div_done) state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign div_start   = (state_q == StScale) && (state_d == StDiv);

  logic [31:0] dbl;
  always_comb begin
    if (best_q[30:23] == 8'd0) dbl = best_q << 1;
    else if (best_q[30:23] == 8'hFE) dbl = PosInfBits;
    else dbl = best_q + 32'h0080_0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fmt_q <= 1'b0; margin_q <= '0;
      wpos_q <= '0; fill_q <= '0; scan_q <= '0;
      rd_vld_q <= 1'b0; scan_last_q <= 1'b0; mcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegFormat) fmt_q <= cfg_wdata_i[0];
        else margin_q <= cfg_wdata_i;
      end
      rd_vld_q <= 1'b0;
      scan_last_q <= 1'b0;
      if (state_q == StWrite) begin
        wpos_q <= (32'(wpos_q) == HistLen - 1) ? '0 : wpos_q + 1'b1;
        if (32'(fill_q) < HistLen) fill_q <= fill_q + 1'b1;
        scan_q <= '0;
        mcnt_q <= '0;
      end else if (state_q == StScan) begin
        // Every scan cycle issues a read; its data is valid in the next one.
        rd_vld_q <= 1'b1;
        if (32'(scan_ext) != HistLen - 1) begin
          scan_q <= scan_q + 1'b1;
        end else if (!scan_last_q) begin
          scan_last_q <= 1'b1;
        end
      end else if (state_q == StScale) begin
        mcnt_q <= mcnt_q + 1'b1;
      end
    end
  end

  // The scan reads entry scan_q; data arrives in the next cycle with the index
  // that was read, held in scan_ext delayed by the pipeline register.
  logic [IdxW:0] rd_idx_q;
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_ext;
    if (state_q == StIdle && in_valid_i)
      amax_q <= (amax_bits_i >= 32'd1 && amax_bits_i <= MaxFinBits) ? amax_bits_i : 32'd0;
    if (state_q == StWrite) best_q <= 32'd0;
    else if (state_q == StScan && rd_vld_q && 32'(rd_idx_q) < 32'(fill_q)
             && rd_q > best_q) best_q <= rd_q;
    else if (state_q == StScale && state_d == StScale) best_q <= dbl;
    if (state_q == StScale && best_q == 32'd0) scale_q <= OneBits;
    else if (div_done) scale_q <= div_q;
  end

  fdst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (best_q),
    .fmt_i   (fmt_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign scale_bits_o   = scale_q;
  assign filled_count_o = fill_q;

`ifndef SYNTH
  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= HistLen) else $error("fill count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(scale_bits_o)) else $error("result changed");
`endif
endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for fp8_delayed_scale_tracker_core.
// Depends on fdst_pkg and the block's RTL; predicts every result internally.
`timescale 1ns / 100ps

module tb;
  import fdst_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = RegFormat;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] amax_bits_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] scale_bits_o;
  logic [4:0]  filled_count_o;

  fp8_delayed_scale_tracker_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [31:0] scale;
    logic [4:0]  filled;
  } scale_result_t;

  // Predictor state.
  logic [31:0]   hist_q [HistLen];
  int unsigned   wr_pos;
  int unsigned   fill_cnt;
  logic          fmt_e5m2;
  logic [7:0]    margin_exp;
  scale_result_t pending_scales[$];

  int  n_errors = 0;
  int  idle_cycles = 0;
  bit  no_idling = 1'b0;
  bit  hold_output = 1'b0;

  function automatic bit is_pos_finite(logic [31:0] b);
    return b >= 32'd1 && b <= MaxFinBits;
  endfunction

  function automatic logic [31:0] double_amax(logic [31:0] b);
    if (b[30:23] == 8'h00) return b << 1;
    if (b[30:23] == 8'hFF) return b;
    b = b + 32'h0080_0000;
    if (b[30:23] == 8'hFF) return PosInfBits;
    return b;
  endfunction

  // Divides a positive binary32 by 7 * 2^k and rounds to nearest even.
  function automatic logic [31:0] divide_by_fp8_max(logic [31:0] x, int k);
    logic [127:0] num, quo, kept, low;
    logic [127:0] bits;
    int  e, p, lsb_exp, sh;
    logic [31:0] rem;
    bit  half, sticky;
    if (x == PosInfBits) return PosInfBits;
    if (x[30:23] == 8'h00) begin
      num = {104'd0, 1'b0, x[22:0]};
      e = -149;
    end else begin
      num = {104'd0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
    num = num << 40;
    quo = num / 7;
    rem = 32'(num % 7);
    p = 0;
    for (int i = 0; i < 128; i++) if (quo[i]) p = i;
    // Value is quo * 2^(e-k-40) plus a remainder term.
    lsb_exp = p + e - k - 40 - 23;
    if (lsb_exp < -149) lsb_exp = -149;
    sh = lsb_exp - (e - k - 40);
    kept = quo >> sh;
    low = quo & ((128'd1 << sh) - 1);
    half = low[sh-1];
    sticky = ((low & ((128'd1 << (sh - 1)) - 1)) != 0) || (rem != 0);
    if (half && (sticky || kept[0])) kept = kept + 1;
    bits = (128'(lsb_exp + 149) << 23) + kept;
    if (bits >= 128'(PosInfBits)) return PosInfBits;
    return bits[31:0];
  endfunction

  function automatic scale_result_t predict_scale(logic [31:0] amax);
    scale_result_t r;
    logic [31:0] best;
    hist_q[wr_pos] = is_pos_finite(amax) ? amax : 32'd0;
    wr_pos = (wr_pos + 1) % HistLen;
    if (fill_cnt < HistLen) fill_cnt++;
    best = '0;
    for (int i = 0; i < HistLen; i++)
      if (is_pos_finite(hist_q[i]) && hist_q[i] > best) best = hist_q[i];
    if (best == 0) begin
      r.scale = OneBits;
    end else begin
      for (int i = 0; i < margin_exp && best != PosInfBits; i++) best = double_amax(best);
      r.scale = divide_by_fp8_max(best, fmt_e5m2 ? 13 : 6);
    end
    r.filled = 5'(fill_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Input monitor: predict on every accepted item; output monitor: compare.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) pending_scales.push_back(predict_scale(amax_bits_i));
  end

  always @(posedge clk_i) begin
    scale_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_scales.size() == 0) begin
        report_mismatch("unexpected result", scale_bits_o, '0);
      end else begin
        want = pending_scales.pop_front();
        if (scale_bits_o !== want.scale) report_mismatch("scale_bits", scale_bits_o, want.scale);
        if (filled_count_o !== want.filled)
          report_mismatch("filled_count", 32'(filled_count_o), 32'(want.filled));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_output) out_ready_i <= 1'b0;
    else out_ready_i <= no_idling || ($urandom_range(99) >= 27);
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 6000) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_amax(logic [31:0] amax);
    while (!no_idling && $urandom_range(99) < 27) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(posedge clk_i);
    in_valid_i  <= 1'b1;
    amax_bits_i <= amax;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_amax();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return $urandom();
      1: return {9'd0, 23'($urandom())};
      2: return {1'b0, 8'($urandom_range(100, 160)), 23'($urandom())};
      3: return {1'b0, 8'($urandom_range(200, 254)), 23'($urandom())};
      default: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
    endcase
  endfunction

  // Registers are written only once every result is back and the block idles.
  // The first edge lets the input monitor record an item accepted just now.
  task automatic write_reg(logic idx, logic [7:0] data);
    @(posedge clk_i);
    wait (pending_scales.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegFormat) fmt_e5m2 = data[0];
    else margin_exp = data;
  endtask

  task automatic test_directed();
    logic [31:0] vals[$] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                             32'h7FC0_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h007F_FFFF,
                             32'h0080_0000, 32'h3F80_0000, 32'h43E0_0000, 32'h4760_0000,
                             32'h7F7F_FFFF, 32'hBF80_0000, 32'h7F80_0001};
    foreach (vals[i]) send_amax(vals[i]);
    // A history of invalid values only must give a scale of one again.
    repeat (HistLen) send_amax(32'h8000_0000);
    send_amax(32'h0000_0000);
  endtask

  task automatic test_settings();
    logic [7:0] margins[$] = '{8'd0, 8'd255, 8'd1, 8'd127, 8'd30};
    foreach (margins[m]) begin
      for (int f = 0; f < 2; f++) begin
        // Upper data bits of the format register must be ignored.
        write_reg(RegFormat, {7'($urandom()), f[0]});
        write_reg(RegMargin, margins[m]);
        repeat ((margins[m] > 100) ? 8 : 30) send_amax(rand_amax());
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_output = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_output = 1'b0;
      end
      repeat (30) send_amax(rand_amax());
    join
  endtask

  task automatic test_random();
    write_reg(RegMargin, 8'd0);
    for (int i = 0; i < 776; i++) begin
      if (i % 85 == 0) begin
        write_reg(RegFormat, 8'($urandom()));
        write_reg(RegMargin, ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(20)));
      end
      no_idling = (i >= 300 && i < 400);
      send_amax(rand_amax());
    end
    no_idling = 1'b0;
  endtask

  initial begin
    foreach (hist_q[i]) hist_q[i] = '0;
    wr_pos = 0;
    fill_cnt = 0;
    fmt_e5m2 = 1'b0;
    margin_exp = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_settings();
    test_backpressure();
    test_random();
    @(posedge clk_i);
    wait (pending_scales.size() == 0);
    repeat (400) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
